[hdl/lennard_jones_pair_force_unit_assert.svh]
// Assertion macros for the Lennard-Jones pair force unit.
// Included by RTL modules that check their own control logic; no dependencies.
`ifndef LENNARD_JONES_PAIR_FORCE_UNIT_ASSERT_SVH
`define LENNARD_JONES_PAIR_FORCE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LJ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define LJ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define LJ_ASSERT(lbl, clk, rst_n, prop)
`define LJ_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hdl/ljpf_pkg.sv]
// Shared types, register codes and arithmetic helpers of the pair force unit.
// No dependencies; used by ljpf_div and lennard_jones_pair_force_unit.
package ljpf_pkg;

    localparam logic [2:0] REG_BOX_X       = 3'd0;
    localparam logic [2:0] REG_BOX_Y       = 3'd1;
    localparam logic [2:0] REG_BOX_Z       = 3'd2;
    localparam logic [2:0] REG_CUT_COLLOID = 3'd3;
    localparam logic [2:0] REG_CUT_INNER   = 3'd4;
    localparam logic [2:0] REG_CUT_OUTER   = 3'd5;
    localparam logic [2:0] REG_SIG_COLLOID = 3'd6;
    localparam logic [2:0] REG_SIG_SOLVENT = 3'd7;

    localparam logic [1:0] KIND_COLLOID = 2'd0;
    localparam logic [1:0] KIND_INNER   = 2'd1;
    localparam logic [1:0] KIND_OUTER   = 2'd2;

    localparam logic [31:0] BOX_RESET   = 32'd268435456;
    localparam logic [63:0] SIGMA_RESET = 64'd281474976710656;

    localparam logic signed [47:0] ENERGY_SHIFT = 48'sd16777216;
    localparam logic signed [47:0] ENERGY_CUT   = 48'sd0;

    localparam logic signed [63:0] POS48 = 64'sd140737488355327;
    localparam logic signed [63:0] NEG48 = -64'sd140737488355328;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] q;
    } t_div_st;

    typedef struct packed {
        logic [63:0] p11;
        logic [63:0] p10;
        logic [63:0] p01;
        logic [63:0] p00;
    } t_pp;

    typedef struct packed {
        logic [1:0]       kind;
        logic             in_cut;
        logic [63:0]      r2;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } t_geo;

    typedef struct packed {
        t_geo        geo;
        logic [63:0] s;
        logic [63:0] s3;
    } t_carry;

    typedef struct packed {
        logic [47:0] u;
        logic        usat;
        logic        in_cut;
        logic        neg;
        logic        zero;
    } t_fside;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_aside;

    typedef struct packed {
        logic [47:0] fx;
        logic [47:0] fy;
        logic [47:0] fz;
        logic [47:0] pot;
        logic        in_cut;
        logic        sat;
    } t_res;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic t_div_st div_step(t_div_st x, logic [63:0] den);
        t_div_st     y;
        logic [64:0] t;
        t    = {x.rem, x.lo[63]};
        y.lo = {x.lo[62:0], 1'b0};
        y.q  = {x.q[62:0], 1'b0};
        if (t >= {1'b0, den}) begin
            t      = t - {1'b0, den};
            y.q[0] = 1'b1;
        end
        y.rem = t[63:0];
        return y;
    endfunction

    function automatic t_pp mul_parts(logic [63:0] a, logic [63:0] b);
        t_pp y;
        y.p00 = a[31:0] * b[31:0];
        y.p01 = a[31:0] * b[63:32];
        y.p10 = a[63:32] * b[31:0];
        y.p11 = a[63:32] * b[63:32];
        return y;
    endfunction

    function automatic logic [127:0] mul_join(t_pp x);
        return {64'b0, x.p00} + {32'b0, x.p01, 32'b0} + {32'b0, x.p10, 32'b0}
             + {x.p11, 64'b0};
    endfunction

    // Q32.32 product, saturated
    function automatic logic [63:0] q32(logic [127:0] p);
        return (p[127:96] != 32'b0) ? {64{1'b1}} : p[95:32];
    endfunction

endpackage

[hdl/ljpf_div.sv]
// Pipelined 128/64 restoring divider with saturation and a sideband payload.
// Depends on ljpf_pkg (div_step, t_div_st).
module ljpf_div #(
    parameter int BITS_PER_STAGE = 2,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_num_hi,
    input  logic [63:0]       i_num_lo,
    input  logic [63:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [63:0]       o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int STAGES = 64 / BITS_PER_STAGE;

    logic                s_v    [STAGES+1];
    ljpf_pkg::t_div_st   s_st   [STAGES+1];
    logic [63:0]         s_den  [STAGES+1];
    logic                s_sat  [STAGES+1];
    logic [SIDE_W-1:0]   s_side [STAGES+1];

    assign s_v[0]    = i_valid;
    assign s_st[0]   = '{rem: i_num_hi, lo: i_num_lo, q: 64'b0};
    assign s_den[0]  = i_den;
    assign s_sat[0]  = (i_den == 64'b0) || (i_num_hi >= i_den);
    assign s_side[0] = i_side;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        ljpf_pkg::t_div_st n_st;
        ljpf_pkg::t_div_st r_st;
        logic              r_v;
        logic [63:0]       r_den;
        logic              r_sat;
        logic [SIDE_W-1:0] r_side;

        always_comb begin
            n_st = s_st[g];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                n_st = ljpf_pkg::div_step(n_st, s_den[g]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st   <= n_st;
                r_den  <= s_den[g];
                r_sat  <= s_sat[g];
                r_side <= s_side[g];
            end
        end

        assign s_v[g+1]    = r_v;
        assign s_st[g+1]   = r_st;
        assign s_den[g+1]  = r_den;
        assign s_sat[g+1]  = r_sat;
        assign s_side[g+1] = r_side;
    end

    assign o_valid = s_v[STAGES];
    assign o_quot  = s_sat[STAGES] ? {64{1'b1}} : s_st[STAGES].q;
    assign o_side  = s_side[STAGES];

endmodule

[hdl/lennard_jones_pair_force_unit.sv]
// Lennard-Jones pair force unit with minimum-image wrap, top level.
// Depends on ljpf_pkg, ljpf_div and lennard_jones_pair_force_unit_assert.svh.
//
// Takes one pair transaction per clock while o_stall is low, and returns one
// result per pair, in order. The pipeline runs through the wrap, squares and
// cutoff-test stages, the sigma^2/r2 divider, six 64x64 multiply steps
// forming the power and its square, the E1 and E2 stages of energy and radial
// factor, the F1 and F2 stages of force products, the three force dividers in
// parallel, and the output register. The two divider pipelines, each retiring
// DIV_BITS quotient bits per stage, set the depth. A skid register behind the
// output keeps the pipe moving while one result waits. Configuration may be
// written only while the unit is empty.
`include "lennard_jones_pair_force_unit_assert.svh"

module lennard_jones_pair_force_unit #(
    parameter int DIV_BITS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_first_x,
    input  logic [31:0]        i_first_y,
    input  logic [31:0]        i_first_z,
    input  logic [31:0]        i_second_x,
    input  logic [31:0]        i_second_y,
    input  logic [31:0]        i_second_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic signed [47:0] o_potential,
    output logic               o_within_cutoff,
    output logic               o_saturated
);

    localparam int MUL_STEPS = 6;

    logic [31:0] r_box_x, r_box_y, r_box_z;
    logic [63:0] r_cut_colloid, r_cut_inner, r_cut_outer;
    logic [63:0] r_sig_colloid, r_sig_solvent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x       <= ljpf_pkg::BOX_RESET;
            r_box_y       <= ljpf_pkg::BOX_RESET;
            r_box_z       <= ljpf_pkg::BOX_RESET;
            r_cut_colloid <= 64'b0;
            r_cut_inner   <= 64'b0;
            r_cut_outer   <= 64'b0;
            r_sig_colloid <= ljpf_pkg::SIGMA_RESET;
            r_sig_solvent <= ljpf_pkg::SIGMA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ljpf_pkg::REG_BOX_X:       r_box_x       <= i_cfg_data[31:0];
                ljpf_pkg::REG_BOX_Y:       r_box_y       <= i_cfg_data[31:0];
                ljpf_pkg::REG_BOX_Z:       r_box_z       <= i_cfg_data[31:0];
                ljpf_pkg::REG_CUT_COLLOID: r_cut_colloid <= i_cfg_data;
                ljpf_pkg::REG_CUT_INNER:   r_cut_inner   <= i_cfg_data;
                ljpf_pkg::REG_CUT_OUTER:   r_cut_outer   <= i_cfg_data;
                ljpf_pkg::REG_SIG_COLLOID: r_sig_colloid <= i_cfg_data;
                ljpf_pkg::REG_SIG_SOLVENT: r_sig_solvent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_sk_v, r_out_v, w_en;
    assign w_en    = !r_sk_v;
    assign o_stall = r_sk_v;

    // stage 1: minimum-image wrap
    logic [2:0][31:0] w_a, w_b, w_box, n_s1_mag;
    logic [2:0]       n_s1_neg;
    assign w_a   = {i_first_z, i_first_y, i_first_x};
    assign w_b   = {i_second_z, i_second_y, i_second_x};
    assign w_box = {r_box_z, r_box_y, r_box_x};

    always_comb begin : wrap
        logic signed [33:0] diff, wd;
        logic signed [34:0] dbl, bx;
        for (int k = 0; k < 3; k++) begin
            diff = $signed({2'b0, w_a[k]}) - $signed({2'b0, w_b[k]});
            dbl  = {diff, 1'b0};
            bx   = $signed({3'b0, w_box[k]});
            if (dbl >= bx) begin
                wd = diff - $signed({2'b0, w_box[k]});
            end else if (dbl < -bx) begin
                wd = diff + $signed({2'b0, w_box[k]});
            end else begin
                wd = diff;
            end
            n_s1_neg[k] = wd[33];
            n_s1_mag[k] = wd[33] ? 32'(-wd) : wd[31:0];
        end
    end

    logic             r_s1_v;
    logic [1:0]       r_s1_kind;
    logic [2:0][31:0] r_s1_mag;
    logic [2:0]       r_s1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_kind <= i_command;
            r_s1_mag  <= n_s1_mag;
            r_s1_neg  <= n_s1_neg;
        end
    end

    // stage 2: squares, kind select
    logic [63:0] n_s2_cut, n_s2_sig;
    always_comb begin
        case (r_s1_kind)
            ljpf_pkg::KIND_COLLOID: begin
                n_s2_cut = r_cut_colloid;
                n_s2_sig = r_sig_colloid;
            end
            ljpf_pkg::KIND_INNER: begin
                n_s2_cut = r_cut_inner;
                n_s2_sig = r_sig_solvent;
            end
            ljpf_pkg::KIND_OUTER: begin
                n_s2_cut = r_cut_outer;
                n_s2_sig = r_sig_solvent;
            end
            default: begin
                n_s2_cut = 64'b0;
                n_s2_sig = r_sig_solvent;
            end
        endcase
    end

    logic             r_s2_v;
    logic [1:0]       r_s2_kind;
    logic [2:0][31:0] r_s2_mag;
    logic [2:0]       r_s2_neg;
    logic [2:0][63:0] r_s2_sq;
    logic [63:0]      r_s2_cut, r_s2_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_kind <= r_s1_kind;
            r_s2_mag  <= r_s1_mag;
            r_s2_neg  <= r_s1_neg;
            r_s2_cut  <= n_s2_cut;
            r_s2_sig  <= n_s2_sig;
            for (int k = 0; k < 3; k++) begin
                r_s2_sq[k] <= r_s1_mag[k] * r_s1_mag[k];
            end
        end
    end

    // stage 3: r^2 with saturation, cutoff test
    logic [65:0]    w_sum;
    ljpf_pkg::t_geo n_s3_geo;
    assign w_sum = {2'b0, r_s2_sq[0]} + {2'b0, r_s2_sq[1]} + {2'b0, r_s2_sq[2]};

    always_comb begin
        n_s3_geo.kind   = r_s2_kind;
        n_s3_geo.r2     = (w_sum[65:64] != 2'b0) ? {64{1'b1}} : w_sum[63:0];
        n_s3_geo.in_cut = n_s3_geo.r2 < r_s2_cut;
        n_s3_geo.mag    = r_s2_mag;
        n_s3_geo.neg    = r_s2_neg;
    end

    logic           r_s3_v;
    ljpf_pkg::t_geo r_s3_geo;
    logic [63:0]    r_s3_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_geo <= n_s3_geo;
            r_s3_sig <= r_s2_sig;
        end
    end

    // s = sigma^2 / r^2 in Q32.32
    logic           w_d1_v;
    logic [63:0]    w_d1_q;
    ljpf_pkg::t_geo w_d1_geo;

    ljpf_div #(
        .BITS_PER_STAGE(DIV_BITS),
        .SIDE_W($bits(ljpf_pkg::t_geo))
    ) u_div_s (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s3_v),
        .i_num_hi ({32'b0, r_s3_sig[63:32]}),
        .i_num_lo ({r_s3_sig[31:0], 32'b0}),
        .i_den    (r_s3_geo.r2),
        .i_side   (r_s3_geo),
        .o_valid  (w_d1_v),
        .o_quot   (w_d1_q),
        .o_side   (w_d1_geo)
    );

    // power chain: s2, s3, s6, s12, s24, then P*P
    logic                 m_v  [MUL_STEPS];
    logic [63:0]          m_a  [MUL_STEPS];
    logic [63:0]          m_b  [MUL_STEPS];
    ljpf_pkg::t_carry     m_c  [MUL_STEPS];
    logic                 r_ma_v    [MUL_STEPS];
    ljpf_pkg::t_pp        r_ma_pp   [MUL_STEPS];
    ljpf_pkg::t_carry     r_ma_c    [MUL_STEPS];
    logic                 r_mb_v    [MUL_STEPS];
    logic [127:0]         r_mb_prod [MUL_STEPS];
    ljpf_pkg::t_carry     r_mb_c    [MUL_STEPS];

    always_comb begin : mul_wiring
        logic [63:0] pw;
        m_v[0]      = w_d1_v;
        m_a[0]      = w_d1_q;
        m_b[0]      = w_d1_q;
        m_c[0].geo  = w_d1_geo;
        m_c[0].s    = w_d1_q;
        m_c[0].s3   = 64'b0;

        m_v[1] = r_mb_v[0];
        m_a[1] = ljpf_pkg::q32(r_mb_prod[0]);
        m_b[1] = r_mb_c[0].s;
        m_c[1] = r_mb_c[0];

        for (int k = 2; k < MUL_STEPS - 1; k++) begin
            m_v[k] = r_mb_v[k-1];
            m_a[k] = ljpf_pkg::q32(r_mb_prod[k-1]);
            m_b[k] = ljpf_pkg::q32(r_mb_prod[k-1]);
            m_c[k] = r_mb_c[k-1];
        end
        m_c[2].s3 = ljpf_pkg::q32(r_mb_prod[1]);

        pw = (r_mb_c[4].geo.kind == ljpf_pkg::KIND_OUTER) ?
             ljpf_pkg::q32(r_mb_prod[4]) : r_mb_c[4].s3;
        m_v[5]   = r_mb_v[4];
        m_a[5]   = pw;
        m_b[5]   = pw;
        m_c[5]   = r_mb_c[4];
        m_c[5].s = pw;
    end

    for (genvar k = 0; k < MUL_STEPS; k++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ma_v[k] <= 1'b0;
                r_mb_v[k] <= 1'b0;
            end else if (w_en) begin
                r_ma_v[k] <= m_v[k];
                r_mb_v[k] <= r_ma_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ma_pp[k]   <= ljpf_pkg::mul_parts(m_a[k], m_b[k]);
                r_ma_c[k]    <= m_c[k];
                r_mb_prod[k] <= ljpf_pkg::mul_join(r_ma_pp[k]);
                r_mb_c[k]    <= r_ma_c[k];
            end
        end
    end

    // E1: potential and radial factor g
    logic [127:0]       w_sq;
    logic [63:0]        w_p;
    ljpf_pkg::t_geo     w_pg;
    logic [47:0]        n_e1_u;
    logic               n_e1_usat;
    logic [95:0]        n_e1_g;
    logic               n_e1_gneg;

    assign w_sq = r_mb_prod[MUL_STEPS-1];
    assign w_p  = r_mb_c[MUL_STEPS-1].s;
    assign w_pg = r_mb_c[MUL_STEPS-1].geo;

    always_comb begin : energy
        logic [60:0]        a40;
        logic signed [63:0] sh, u;
        logic [95:0]        a32, half;
        if (w_sq[127:101] != 27'b0 || w_sq[100:40] > {1'b1, 60'b0}) begin
            a40 = {1'b1, 60'b0};
        end else begin
            a40 = w_sq[100:40];
        end
        sh = (w_pg.kind == ljpf_pkg::KIND_OUTER) ? -(64'(ljpf_pkg::ENERGY_CUT))
                                                  : 64'(ljpf_pkg::ENERGY_SHIFT);
        u = $signed({1'b0, a40, 2'b0}) - $signed({6'b0, w_p[63:8], 2'b0}) + sh;
        if (u > ljpf_pkg::POS48) begin
            n_e1_u    = ljpf_pkg::POS48[47:0];
            n_e1_usat = 1'b1;
        end else if (u < ljpf_pkg::NEG48) begin
            n_e1_u    = ljpf_pkg::NEG48[47:0];
            n_e1_usat = 1'b1;
        end else begin
            n_e1_u    = u[47:0];
            n_e1_usat = 1'b0;
        end
        a32  = w_sq[127:32];
        half = {33'b0, w_p[63:1]};
        if (a32 >= half) begin
            n_e1_g    = a32 - half;
            n_e1_gneg = 1'b0;
        end else begin
            n_e1_g    = half - a32;
            n_e1_gneg = 1'b1;
        end
    end

    logic           r_e1_v;
    logic [47:0]    r_e1_u;
    logic           r_e1_usat;
    logic [95:0]    r_e1_g;
    logic           r_e1_gneg;
    ljpf_pkg::t_geo r_e1_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (w_en) begin
            r_e1_v <= r_mb_v[MUL_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_u    <= n_e1_u;
            r_e1_usat <= n_e1_usat;
            r_e1_g    <= n_e1_g;
            r_e1_gneg <= n_e1_gneg;
            r_e1_geo  <= w_pg;
        end
    end

    // E2: G = g * 48 or g * 384
    logic [104:0] n_e2_big;
    assign n_e2_big = (r_e1_geo.kind == ljpf_pkg::KIND_OUTER) ?
                      ({1'b0, r_e1_g, 8'b0} + {2'b0, r_e1_g, 7'b0}) :
                      ({4'b0, r_e1_g, 5'b0} + {5'b0, r_e1_g, 4'b0});

    logic             r_e2_v;
    logic [104:0]     r_e2_big;
    logic [47:0]      r_e2_u;
    logic             r_e2_usat;
    logic             r_e2_in_cut;
    logic [63:0]      r_e2_r2;
    logic [2:0][31:0] r_e2_mag;
    logic [2:0]       r_e2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else if (w_en) begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_big    <= n_e2_big;
            r_e2_u      <= r_e1_u;
            r_e2_usat   <= r_e1_usat;
            r_e2_in_cut <= r_e1_geo.in_cut;
            r_e2_r2     <= r_e1_geo.r2;
            r_e2_mag    <= r_e1_geo.mag;
            r_e2_neg    <= r_e1_geo.neg ^ {3{r_e1_gneg}};
        end
    end

    // F1: G * |d| partial products per axis
    logic             r_f1_v;
    logic [2:0][63:0] r_f1_p0, r_f1_p1, r_f1_p2;
    logic [2:0][40:0] r_f1_p3;
    logic [47:0]      r_f1_u;
    logic             r_f1_usat;
    logic             r_f1_in_cut;
    logic [63:0]      r_f1_r2;
    logic [2:0]       r_f1_zero;
    logic [2:0]       r_f1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_f1_p0[k]   <= r_e2_big[31:0] * r_e2_mag[k];
                r_f1_p1[k]   <= r_e2_big[63:32] * r_e2_mag[k];
                r_f1_p2[k]   <= r_e2_big[95:64] * r_e2_mag[k];
                r_f1_p3[k]   <= r_e2_big[104:96] * r_e2_mag[k];
                r_f1_zero[k] <= (r_e2_mag[k] == 32'b0);
            end
            r_f1_u      <= r_e2_u;
            r_f1_usat   <= r_e2_usat;
            r_f1_in_cut <= r_e2_in_cut;
            r_f1_r2     <= r_e2_r2;
            r_f1_neg    <= r_e2_neg;
        end
    end

    // F2: join products, scale by 2^16, saturate to 128 bits
    logic [2:0][127:0] n_f2_num;
    always_comb begin : fjoin
        logic [136:0] t;
        for (int k = 0; k < 3; k++) begin
            t = {73'b0, r_f1_p0[k]} + {41'b0, r_f1_p1[k], 32'b0}
              + {9'b0, r_f1_p2[k], 64'b0} + {r_f1_p3[k], 96'b0};
            n_f2_num[k] = (t[136:112] != 25'b0) ? {128{1'b1}} : {t[111:0], 16'b0};
        end
    end

    logic              r_f2_v;
    logic [2:0][127:0] r_f2_num;
    logic [63:0]       r_f2_r2;
    ljpf_pkg::t_fside  r_f2_sx;
    ljpf_pkg::t_aside  r_f2_sy, r_f2_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_num <= n_f2_num;
            r_f2_r2  <= r_f1_r2;
            r_f2_sx  <= '{u: r_f1_u, usat: r_f1_usat, in_cut: r_f1_in_cut,
                          neg: r_f1_neg[0], zero: r_f1_zero[0]};
            r_f2_sy  <= '{neg: r_f1_neg[1], zero: r_f1_zero[1]};
            r_f2_sz  <= '{neg: r_f1_neg[2], zero: r_f1_zero[2]};
        end
    end

    // force dividers, one per axis
    logic             w_dx_v, w_dy_v, w_dz_v;
    logic [2:0][63:0] w_mq;
    ljpf_pkg::t_fside w_sx;
    ljpf_pkg::t_aside w_sy, w_sz;

    ljpf_div #(
        .BITS_PER_STAGE(DIV_BITS),
        .SIDE_W($bits(ljpf_pkg::t_fside))
    ) u_div_fx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_f2_v),
        .i_num_hi (r_f2_num[0][127:64]),
        .i_num_lo (r_f2_num[0][63:0]),
        .i_den    (r_f2_r2),
        .i_side   (r_f2_sx),
        .o_valid  (w_dx_v),
        .o_quot   (w_mq[0]),
        .o_side   (w_sx)
    );

    ljpf_div #(
        .BITS_PER_STAGE(DIV_BITS),
        .SIDE_W($bits(ljpf_pkg::t_aside))
    ) u_div_fy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_f2_v),
        .i_num_hi (r_f2_num[1][127:64]),
        .i_num_lo (r_f2_num[1][63:0]),
        .i_den    (r_f2_r2),
        .i_side   (r_f2_sy),
        .o_valid  (w_dy_v),
        .o_quot   (w_mq[1]),
        .o_side   (w_sy)
    );

    ljpf_div #(
        .BITS_PER_STAGE(DIV_BITS),
        .SIDE_W($bits(ljpf_pkg::t_aside))
    ) u_div_fz (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_f2_v),
        .i_num_hi (r_f2_num[2][127:64]),
        .i_num_lo (r_f2_num[2][63:0]),
        .i_den    (r_f2_r2),
        .i_side   (r_f2_sz),
        .o_valid  (w_dz_v),
        .o_quot   (w_mq[2]),
        .o_side   (w_sz)
    );

    // final clip and result assembly
    ljpf_pkg::t_res w_res;
    always_comb begin : assemble
        logic [2:0]       neg, zero, fsat;
        logic [2:0][47:0] f;
        logic [63:0]      lim;
        neg  = {w_sz.neg, w_sy.neg, w_sx.neg};
        zero = {w_sz.zero, w_sy.zero, w_sx.zero};
        for (int k = 0; k < 3; k++) begin
            lim = neg[k] ? {16'b0, 1'b1, 47'b0} : {17'b0, {47{1'b1}}};
            fsat[k] = 1'b0;
            if (zero[k]) begin
                f[k] = 48'b0;
            end else if (w_mq[k] > lim) begin
                fsat[k] = 1'b1;
                f[k] = neg[k] ? (~lim[47:0] + 48'd1) : lim[47:0];
            end else begin
                f[k] = neg[k] ? (~w_mq[k][47:0] + 48'd1) : w_mq[k][47:0];
            end
        end
        w_res.in_cut = w_sx.in_cut;
        w_res.fx     = w_sx.in_cut ? f[0] : 48'b0;
        w_res.fy     = w_sx.in_cut ? f[1] : 48'b0;
        w_res.fz     = w_sx.in_cut ? f[2] : 48'b0;
        w_res.pot    = w_sx.in_cut ? w_sx.u : 48'b0;
        w_res.sat    = w_sx.in_cut && (w_sx.usat || (fsat != 3'b0));
    end

    // output register and skid
    ljpf_pkg::t_res r_out, r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (!i_stall) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_v <= w_dx_v;
        end else begin
            r_sk_v <= w_dx_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (!i_stall) begin
                r_out <= r_sk;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out <= w_res;
        end else begin
            r_sk <= w_res;
        end
    end

    assign o_valid         = r_out_v;
    assign o_force_x       = r_out.fx;
    assign o_force_y       = r_out.fy;
    assign o_force_z       = r_out.fz;
    assign o_potential     = r_out.pot;
    assign o_within_cutoff = r_out.in_cut;
    assign o_saturated     = r_out.sat;

    `LJ_ASSERT(a_skid_has_out, i_clk, i_rst_n, r_sk_v |-> r_out_v)
    `LJ_ASSERT(a_skid_drains, i_clk, i_rst_n, (r_sk_v && !i_stall) |=> !r_sk_v)
    `LJ_ASSERT_NEVER(a_lanes_aligned, i_clk, i_rst_n, (w_dx_v != w_dy_v) || (w_dx_v != w_dz_v))
    `LJ_ASSERT_NEVER(a_sat_outside, i_clk, i_rst_n, r_out_v && !r_out.in_cut && r_out.sat)

endmodule

[tb/lennard_jones_pair_force_unit_test.sv]
// Self-checking testbench for lennard_jones_pair_force_unit: drives pair transactions
// through several register settings and checks every result against a local predictor.
// Depends on ljpf_pkg and the lennard_jones_pair_force_unit RTL.
module lennard_jones_pair_force_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [63:0] ONE_Q48 = 64'd1 << 48;
    localparam logic [31:0] ONE_Q24 = 32'd1 << 24;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic signed [47:0] fz;
        logic signed [47:0] pot;
        logic               in_cut;
        logic               sat;
    } pair_result_t;

    class ljpf_scoreboard;
        logic [31:0]  box[3];
        logic [63:0]  cut[3];
        logic [63:0]  sig_colloid;
        logic [63:0]  sig_solvent;
        pair_result_t pending[$];
        int           errors;

        function void reset_regs();
            foreach (box[k]) box[k] = ljpf_pkg::BOX_RESET;
            foreach (cut[k]) cut[k] = 64'd0;
            sig_colloid = ljpf_pkg::SIGMA_RESET;
            sig_solvent = ljpf_pkg::SIGMA_RESET;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                ljpf_pkg::REG_BOX_X:       box[0] = val[31:0];
                ljpf_pkg::REG_BOX_Y:       box[1] = val[31:0];
                ljpf_pkg::REG_BOX_Z:       box[2] = val[31:0];
                ljpf_pkg::REG_CUT_COLLOID: cut[0] = val;
                ljpf_pkg::REG_CUT_INNER:   cut[1] = val;
                ljpf_pkg::REG_CUT_OUTER:   cut[2] = val;
                ljpf_pkg::REG_SIG_COLLOID: sig_colloid = val;
                ljpf_pkg::REG_SIG_SOLVENT: sig_solvent = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
            logic [127:0] q;
            if (den == 64'd0 || num[127:64] >= den)
                return {64{1'b1}};
            q = num / {64'd0, den};
            return q[63:0];
        endfunction

        function logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return (p[127:96] != 32'd0) ? {64{1'b1}} : p[95:32];
        endfunction

        function pair_result_t predict(logic [1:0] kind, logic [31:0] fp[3], logic [31:0] sp[3]);
            pair_result_t res;
            longint       d[3];
            longint       bx;
            longint       u;
            longint       shift;
            logic [63:0]  mag[3];
            logic [63:0]  r2;
            logic [63:0]  t;
            logic [64:0]  sum;
            logic [63:0]  cutv;
            logic [63:0]  sigma;
            logic [63:0]  s;
            logic [63:0]  p;
            logic [63:0]  e;
            logic [63:0]  half;
            logic [63:0]  mq;
            logic [63:0]  lim;
            logic [127:0] sq;
            logic [127:0] a;
            logic [127:0] g;
            logic [127:0] num;
            logic [135:0] gm;
            logic [191:0] pr;
            logic         gneg;
            logic         neg;
            logic [47:0]  f[3];
            int           mult;
            res = '{default: '0};
            r2 = 64'd0;
            for (int k = 0; k < 3; k++) begin
                d[k] = longint'({32'd0, fp[k]}) - longint'({32'd0, sp[k]});
                bx = longint'({32'd0, box[k]});
                if (2 * d[k] >= bx)
                    d[k] -= bx;
                else if (2 * d[k] < -bx)
                    d[k] += bx;
                mag[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
                t = mag[k] * mag[k];
                sum = {1'b0, r2} + {1'b0, t};
                r2 = sum[64] ? {64{1'b1}} : sum[63:0];
            end
            case (kind)
                ljpf_pkg::KIND_COLLOID: begin
                    cutv = cut[0]; sigma = sig_colloid; mult = 48;
                    shift = longint'(ljpf_pkg::ENERGY_SHIFT);
                end
                ljpf_pkg::KIND_INNER: begin
                    cutv = cut[1]; sigma = sig_solvent; mult = 48;
                    shift = longint'(ljpf_pkg::ENERGY_SHIFT);
                end
                ljpf_pkg::KIND_OUTER: begin
                    cutv = cut[2]; sigma = sig_solvent; mult = 384;
                    shift = -longint'(ljpf_pkg::ENERGY_CUT);
                end
                default: return res;
            endcase
            if (!(r2 < cutv))
                return res;
            res.in_cut = 1'b1;
            s = div_sat({32'd0, sigma, 32'd0}, r2);
            p = mul_q32(mul_q32(s, s), s);
            if (kind == ljpf_pkg::KIND_OUTER) begin
                p = mul_q32(p, p);
                p = mul_q32(p, p);
                p = mul_q32(p, p);
            end
            sq = {64'd0, p} * {64'd0, p};
            a = sq >> 40;
            e = (a > (128'd1 << 60)) ? (64'd1 << 60) : a[63:0];
            u = 4 * longint'(e) - 4 * longint'(p >> 8) + shift;
            if (u > longint'(ljpf_pkg::POS48)) begin
                u = longint'(ljpf_pkg::POS48); res.sat = 1'b1;
            end
            if (u < longint'(ljpf_pkg::NEG48)) begin
                u = longint'(ljpf_pkg::NEG48); res.sat = 1'b1;
            end
            res.pot = u[47:0];
            a = sq >> 32;
            half = p >> 1;
            if (a >= {64'd0, half}) begin
                gneg = 1'b0; g = a - {64'd0, half};
            end else begin
                gneg = 1'b1; g = {64'd0, half} - a;
            end
            gm = {8'd0, g} * 136'(mult);
            g = (gm[135:128] != 8'd0) ? {128{1'b1}} : gm[127:0];
            for (int k = 0; k < 3; k++) begin
                f[k] = 48'd0;
                if (mag[k] != 64'd0) begin
                    pr = {64'd0, g} * {128'd0, mag[k] << 16};
                    num = (pr[191:128] != 64'd0) ? {128{1'b1}} : pr[127:0];
                    mq = div_sat(num, r2);
                    neg = gneg ^ (d[k] < 0);
                    lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
                    if (mq > lim) begin
                        mq = lim; res.sat = 1'b1;
                    end
                    f[k] = neg ? 48'(-mq) : mq[47:0];
                end
            end
            res.fx = f[0];
            res.fy = f[1];
            res.fz = f[2];
            return res;
        endfunction

        function void note_pair(logic [1:0] kind, logic [31:0] fp[3], logic [31:0] sp[3]);
            pending.push_back(predict(kind, fp, sp));
        endfunction

        function void check_result(pair_result_t got);
            pair_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.fx !== want.fx) begin
                $display("%0t: force_x exp %h act %h", $time, want.fx, got.fx); errors++;
            end
            if (got.fy !== want.fy) begin
                $display("%0t: force_y exp %h act %h", $time, want.fy, got.fy); errors++;
            end
            if (got.fz !== want.fz) begin
                $display("%0t: force_z exp %h act %h", $time, want.fz, got.fz); errors++;
            end
            if (got.pot !== want.pot) begin
                $display("%0t: potential exp %h act %h", $time, want.pot, got.pot); errors++;
            end
            if (got.in_cut !== want.in_cut) begin
                $display("%0t: within_cutoff exp %b act %b", $time, want.in_cut, got.in_cut);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated exp %b act %b", $time, want.sat, got.sat); errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = ljpf_pkg::REG_BOX_X;
    logic [63:0]        i_cfg_data = 64'd0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_command = ljpf_pkg::KIND_COLLOID;
    logic [31:0]        i_first_x = 32'd0;
    logic [31:0]        i_first_y = 32'd0;
    logic [31:0]        i_first_z = 32'd0;
    logic [31:0]        i_second_x = 32'd0;
    logic [31:0]        i_second_y = 32'd0;
    logic [31:0]        i_second_z = 32'd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [47:0] o_force_x;
    logic signed [47:0] o_force_y;
    logic signed [47:0] o_force_z;
    logic signed [47:0] o_potential;
    logic               o_within_cutoff;
    logic               o_saturated;

    ljpf_scoreboard sb = new();
    bit idle_on = 1'b1;

    lennard_jones_pair_force_unit u_top (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("lennard_jones_pair_force_unit_test: FAIL");
        $finish;
    end

    // result monitor: values read here are the ones present at the edge
    always @(posedge i_clk) begin
        pair_result_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.fx = o_force_x;
            got.fy = o_force_y;
            got.fz = o_force_z;
            got.pot = o_potential;
            got.in_cut = o_within_cutoff;
            got.sat = o_saturated;
            sb.check_result(got);
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    task automatic send_pair(logic [1:0] kind, logic [31:0] fp[3], logic [31:0] sp[3]);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_command <= kind;
        i_first_x <= fp[0];
        i_first_y <= fp[1];
        i_first_z <= fp[2];
        i_second_x <= sp[0];
        i_second_y <= sp[1];
        i_second_z <= sp[2];
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_pair(kind, fp, sp);
    endtask

    task automatic send_xyz(logic [1:0] kind, logic [31:0] fx, logic [31:0] fy,
                            logic [31:0] fz, logic [31:0] sx, logic [31:0] sy,
                            logic [31:0] sz);
        logic [31:0] fp[3];
        logic [31:0] sp[3];
        fp = '{fx, fy, fz};
        sp = '{sx, sy, sz};
        send_pair(kind, fp, sp);
    endtask

    task automatic send_random(int count);
        logic [31:0] fp[3];
        logic [31:0] sp[3];
        logic [31:0] off;
        logic [1:0]  kind;
        int          r;
        int          span;
        repeat (count) begin
            r = $urandom_range(0, 15);
            kind = (r == 0) ? KIND_NONE : 2'(r % 3);
            span = $urandom_range(0, 4);
            for (int k = 0; k < 3; k++) begin
                fp[k] = $urandom;
                case (span)
                    0: off = $urandom_range(0, 1 << 18);
                    1: off = $urandom_range(0, 1 << 23);
                    2: off = $urandom_range(0, 3 << 23);
                    3: off = $urandom_range(0, 1 << 25);
                    default: off = $urandom_range(0, 1 << 28);
                endcase
                if ($urandom_range(0, 1))
                    off = -off;
                if ($urandom_range(0, 7) == 0)
                    off += $urandom_range(0, 1) ? sb.box[k] : -sb.box[k];
                sp[k] = ($urandom_range(0, 9) == 0) ? $urandom : fp[k] + off;
            end
            send_pair(kind, fp, sp);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                              logic [63:0] cc, logic [63:0] ci, logic [63:0] co,
                              logic [63:0] sc, logic [63:0] ss);
        write_reg(ljpf_pkg::REG_BOX_X, {32'd0, bx});
        write_reg(ljpf_pkg::REG_BOX_Y, {32'd0, by});
        write_reg(ljpf_pkg::REG_BOX_Z, {32'd0, bz});
        write_reg(ljpf_pkg::REG_CUT_COLLOID, cc);
        write_reg(ljpf_pkg::REG_CUT_INNER, ci);
        write_reg(ljpf_pkg::REG_CUT_OUTER, co);
        write_reg(ljpf_pkg::REG_SIG_COLLOID, sc);
        write_reg(ljpf_pkg::REG_SIG_SOLVENT, ss);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int wait_cycles;
        sb.reset_regs();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every cutoff is zero, so nothing interacts
        send_xyz(ljpf_pkg::KIND_COLLOID, 0, 0, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_INNER, ONE_Q24, 0, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_OUTER, '1, '1, '1, 0, 0, 0);
        send_xyz(KIND_NONE, 0, 0, 0, '1, '1, '1);
        drain();

        write_regs(32'd1 << 25, 32'd1 << 28, '1,
                   (64'd25 << 48) >> 2, (64'd36 << 48) / 25, (64'd9 << 48) >> 2,
                   ONE_Q48, ONE_Q48);
        send_xyz(ljpf_pkg::KIND_COLLOID, 5, 7, 9, 5, 7, 9);
        send_xyz(ljpf_pkg::KIND_OUTER, '1, '1, '1, '1, '1, '1);
        send_xyz(ljpf_pkg::KIND_COLLOID, ONE_Q24, 0, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_COLLOID, 0, 0, 0, ONE_Q24, 0, 0);
        send_xyz(ljpf_pkg::KIND_INNER, ONE_Q24 + 1, 0, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_INNER, 0, ONE_Q24 + 1, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_OUTER, 0, 0, 32'h0119_9999, 0, 0, 0);
        send_xyz(KIND_NONE, 0, 0, 32'h0119_9999, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_COLLOID, 0, 0, 1 << 22, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_OUTER, 1 << 22, 0, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_INNER, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
                 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_COLLOID, '1, '1, '1, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_COLLOID, 0, 0, 0, '1, '1, '1);
        send_xyz(ljpf_pkg::KIND_OUTER, 32'h0100_0000, 32'h0110_0000, 0, 0, 0, 0);
        send_xyz(ljpf_pkg::KIND_COLLOID, 32'h0110_0000, 32'hFFFF_0000, 32'h0000_1000,
                 0, 0, 0);
        send_random(75);
        drain();
        send_random(75);
        drain();

        write_regs(32'd1, 32'd1, ONE_Q24, '1, '1, '1, '1, '1);
        send_random(120);
        drain();

        write_regs($urandom | 32'd1, $urandom | 32'd1, $urandom | 32'd1,
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   64'd0, 64'($urandom) << 16);
        send_random(120);
        drain();

        write_regs(32'd1 << 27, 32'd1 << 27, 32'd1 << 27,
                   64'd9 << 48, ONE_Q48, 64'd4 << 48,
                   (64'd9 << 48) >> 2, ONE_Q48 >> 2);
        idle_on = 1'b0;
        send_random(230);

        i_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("lennard_jones_pair_force_unit_test: PASS");
        else
            $display("lennard_jones_pair_force_unit_test: FAIL");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/ljpf_pkg.sv
hdl/ljpf_div.sv
hdl/lennard_jones_pair_force_unit.sv
tb/lennard_jones_pair_force_unit_test.sv
